### design/adckey_pkg.sv
// ----------------------------------------------------------------------------
// adckey_pkg: shared definitions for the ladder keypad decoder
// Field widths, register indexes, reset values, codes and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package adckey_pkg;

  // defaults for the top level parameters
  localparam int unsigned SAMPLES_DEF     = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COMBO_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_KEY_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_KEY_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN_MS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN_MS       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG_MIN_MS  = 3'd7;

  // register reset values
  localparam logic [LIMIT_W-1:0] RST_COMBO_LIMIT       = 12'd300;
  localparam logic [LIMIT_W-1:0] RST_FIRST_KEY_LIMIT   = 12'd1000;
  localparam logic [LIMIT_W-1:0] RST_SECOND_KEY_LIMIT  = 12'd2000;
  localparam logic [LIMIT_W-1:0] RST_PRESS_THRESHOLD   = 12'd3000;
  localparam logic [LIMIT_W-1:0] RST_RELEASE_THRESHOLD = 12'd3800;
  localparam logic [MS_W-1:0]    RST_CLICK_MIN_MS      = 16'd40;
  localparam logic [MS_W-1:0]    RST_LONG_MIN_MS       = 16'd2000;
  localparam logic [MS_W-1:0]    RST_VERY_LONG_MIN_MS  = 16'd6000;

  // press phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_SAMPLING = 2'd1;
  localparam logic [1:0] PH_WAITING  = 2'd2;

  // key codes
  localparam logic [1:0] KEY_COMBO  = 2'd0;
  localparam logic [1:0] KEY_NEXT   = 2'd1;
  localparam logic [1:0] KEY_RECORD = 2'd2;
  localparam logic [1:0] KEY_PLAY   = 2'd3;

  // press classes
  localparam logic [1:0] CLS_CLICK     = 2'd0;
  localparam logic [1:0] CLS_LONG      = 2'd1;
  localparam logic [1:0] CLS_VERY_LONG = 2'd2;

  typedef struct packed {
    logic [LIMIT_W-1:0] combo_limit;
    logic [LIMIT_W-1:0] first_key_limit;
    logic [LIMIT_W-1:0] second_key_limit;
    logic [LIMIT_W-1:0] press_threshold;
    logic [LIMIT_W-1:0] release_threshold;
    logic [MS_W-1:0]    click_min_ms;
    logic [MS_W-1:0]    long_min_ms;
    logic [MS_W-1:0]    very_long_min_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] key_id;
    logic [1:0] press_class;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       tally_zero;
  } status_t;

endpackage

`default_nettype wire

### design/adckey_cfg_regs.sv
// ----------------------------------------------------------------------------
// adckey_cfg_regs: configuration register file
// Eight write-only threshold and timing registers, masked to their widths.
// ----------------------------------------------------------------------------
`default_nettype none

module adckey_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [adckey_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [adckey_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output adckey_pkg::cfg_t                       cfg_o
);

  adckey_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        adckey_pkg::CFG_COMBO_LIMIT:
          cfg_d.combo_limit = cfg_wdata_i[adckey_pkg::LIMIT_W-1:0];
        adckey_pkg::CFG_FIRST_KEY_LIMIT:
          cfg_d.first_key_limit = cfg_wdata_i[adckey_pkg::LIMIT_W-1:0];
        adckey_pkg::CFG_SECOND_KEY_LIMIT:
          cfg_d.second_key_limit = cfg_wdata_i[adckey_pkg::LIMIT_W-1:0];
        adckey_pkg::CFG_PRESS_THRESHOLD:
          cfg_d.press_threshold = cfg_wdata_i[adckey_pkg::LIMIT_W-1:0];
        adckey_pkg::CFG_RELEASE_THRESHOLD:
          cfg_d.release_threshold = cfg_wdata_i[adckey_pkg::LIMIT_W-1:0];
        adckey_pkg::CFG_CLICK_MIN_MS:
          cfg_d.click_min_ms = cfg_wdata_i[adckey_pkg::MS_W-1:0];
        adckey_pkg::CFG_LONG_MIN_MS:
          cfg_d.long_min_ms = cfg_wdata_i[adckey_pkg::MS_W-1:0];
        adckey_pkg::CFG_VERY_LONG_MIN_MS:
          cfg_d.very_long_min_ms = cfg_wdata_i[adckey_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.combo_limit       <= adckey_pkg::RST_COMBO_LIMIT;
      cfg_q.first_key_limit   <= adckey_pkg::RST_FIRST_KEY_LIMIT;
      cfg_q.second_key_limit  <= adckey_pkg::RST_SECOND_KEY_LIMIT;
      cfg_q.press_threshold   <= adckey_pkg::RST_PRESS_THRESHOLD;
      cfg_q.release_threshold <= adckey_pkg::RST_RELEASE_THRESHOLD;
      cfg_q.click_min_ms      <= adckey_pkg::RST_CLICK_MIN_MS;
      cfg_q.long_min_ms       <= adckey_pkg::RST_LONG_MIN_MS;
      cfg_q.very_long_min_ms  <= adckey_pkg::RST_VERY_LONG_MIN_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/adckey_in_stage.sv
// ----------------------------------------------------------------------------
// adckey_in_stage: input request register
// Holds one accepted request until the decode step consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module adckey_in_stage #(
  parameter int unsigned SAMPLE_BITS = adckey_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic                   kind_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   adv_i,
  output      logic                   vld_o,
  output      logic                   kind_o,
  output      logic [SAMPLE_BITS-1:0] sample_o
);

  logic                   vld_q;
  logic                   kind_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   take;

  assign in_stall_o = vld_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (adv_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= kind_i;
      sample_q <= sample_i;
    end
  end

  assign vld_o    = vld_q;
  assign kind_o   = kind_q;
  assign sample_o = sample_q;

endmodule

`default_nettype wire

### design/adckey_press_fsm.sv
// ----------------------------------------------------------------------------
// adckey_press_fsm: press tracking and release decode
// Keeps the press state and classifies key and duration on release.
// ----------------------------------------------------------------------------
`default_nettype none

module adckey_press_fsm #(
  parameter int unsigned SAMPLES     = adckey_pkg::SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = adckey_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   go_i,
  input  wire logic                   kind_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire adckey_pkg::cfg_t       cfg_i,
  output      logic                   res_vld_o,
  output adckey_pkg::result_t         result_o,
  output adckey_pkg::status_t         status_o
);

  localparam int unsigned TALLY_W = $clog2(SAMPLES + 1);
  localparam int unsigned CMP_W   = (SAMPLE_BITS > adckey_pkg::LIMIT_W) ?
                                    SAMPLE_BITS : adckey_pkg::LIMIT_W;
  localparam int unsigned PROD_W  = (adckey_pkg::LIMIT_W + TALLY_W > adckey_pkg::SUM_W) ?
                                    adckey_pkg::LIMIT_W + TALLY_W : adckey_pkg::SUM_W;
  localparam int unsigned SUM_W   = adckey_pkg::SUM_W;
  localparam int unsigned MS_W    = adckey_pkg::MS_W;

  logic [1:0]         phase_q, phase_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [MS_W-1:0]    ms_q, ms_d;

  logic [CMP_W-1:0]   samp_ext;
  logic               is_low, is_rel;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic [TALLY_W-1:0] tally_inc;
  logic               tally_full;
  logic [PROD_W-1:0]  sum_ext, prod_combo, prod_first, prod_second;
  logic [1:0]         key;
  logic [1:0]         cls;
  logic               has_cls;

  assign samp_ext = CMP_W'(sample_i);
  assign is_low   = !kind_i && (samp_ext < CMP_W'(cfg_i.press_threshold));
  assign is_rel   = !kind_i && !is_low && (samp_ext > CMP_W'(cfg_i.release_threshold));

  // saturating accumulate
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sample_i);
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  assign tally_inc  = tally_q + TALLY_W'(1);
  assign tally_full = (tally_inc >= TALLY_W'(SAMPLES));

  // floor(sum / tally) < limit  <=>  sum < limit * tally
  assign sum_ext     = PROD_W'(sum_q);
  assign prod_combo  = PROD_W'(cfg_i.combo_limit) * PROD_W'(tally_q);
  assign prod_first  = PROD_W'(cfg_i.first_key_limit) * PROD_W'(tally_q);
  assign prod_second = PROD_W'(cfg_i.second_key_limit) * PROD_W'(tally_q);

  always_comb begin
    if (sum_ext < prod_combo) begin
      key = adckey_pkg::KEY_COMBO;
    end else if (sum_ext < prod_first) begin
      key = adckey_pkg::KEY_NEXT;
    end else if (sum_ext < prod_second) begin
      key = adckey_pkg::KEY_RECORD;
    end else begin
      key = adckey_pkg::KEY_PLAY;
    end
  end

  always_comb begin
    has_cls = 1'b1;
    if (ms_q > cfg_i.very_long_min_ms) begin
      cls = adckey_pkg::CLS_VERY_LONG;
    end else if (ms_q > cfg_i.long_min_ms) begin
      cls = adckey_pkg::CLS_LONG;
    end else if (ms_q > cfg_i.click_min_ms) begin
      cls = adckey_pkg::CLS_CLICK;
    end else begin
      cls     = adckey_pkg::CLS_CLICK;
      has_cls = 1'b0;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    tally_d   = tally_q;
    ms_d      = ms_q;
    res_vld_o = 1'b0;
    if (go_i) begin
      if (kind_i) begin
        // ms tick, saturating
        if (phase_q != adckey_pkg::PH_IDLE && ms_q != '1) begin
          ms_d = ms_q + MS_W'(1);
        end
      end else if (is_low) begin
        case (phase_q)
          adckey_pkg::PH_IDLE: begin
            sum_d   = SUM_W'(sample_i);
            tally_d = TALLY_W'(1);
            ms_d    = '0;
            phase_d = (TALLY_W'(1) >= TALLY_W'(SAMPLES)) ?
                      adckey_pkg::PH_WAITING : adckey_pkg::PH_SAMPLING;
          end
          adckey_pkg::PH_SAMPLING: begin
            sum_d   = sum_sat;
            tally_d = tally_inc;
            phase_d = tally_full ? adckey_pkg::PH_WAITING : adckey_pkg::PH_SAMPLING;
          end
          default: ;
        endcase
      end else if (is_rel && phase_q != adckey_pkg::PH_IDLE) begin
        // every release clears the press, short ones just report nothing
        phase_d   = adckey_pkg::PH_IDLE;
        sum_d     = '0;
        tally_d   = '0;
        ms_d      = '0;
        res_vld_o = has_cls;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= adckey_pkg::PH_IDLE;
      sum_q   <= '0;
      tally_q <= '0;
      ms_q    <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      tally_q <= tally_d;
      ms_q    <= ms_d;
    end
  end

  assign result_o.key_id      = key;
  assign result_o.press_class = cls;
  assign status_o.phase       = phase_q;
  assign status_o.tally_zero  = (tally_q == '0);

endmodule

`default_nettype wire

### design/adckey_out_stage.sv
// ----------------------------------------------------------------------------
// adckey_out_stage: result register
// Holds one decoded key event until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module adckey_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire adckey_pkg::result_t result_i,
  output      logic                space_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [1:0]          key_id_o,
  output      logic [1:0]          press_class_o
);

  logic                vld_q;
  adckey_pkg::result_t res_q;

  // free, or emptied at this edge
  assign space_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_i) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o   = vld_q;
  assign key_id_o      = res_q.key_id;
  assign press_class_o = res_q.press_class;

endmodule

`default_nettype wire

### design/adc_ladder_key_decoder_core.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder_core: resistor ladder keypad decoder
// Turns a stream of ADC samples and ms ticks into key press events.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one request, kind_i picks an
//   adc sample (0) or a one ms tick (1), sample_i holds the conversion
//   output channel: out_valid_o / out_stall_i carry one key event with
//   key_id_o and press_class_o, sent only on a reported release
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i, write
//   only while no request is in flight
//   path: out_valid_o is driven by the result register, so the event of a
//   request passes in order through the input register, one decode step
//   and the result register
//   throughput: one request per cycle, set by the single decode step that
//   updates the press state; only a stalled waiting result blocks input
//   stall: when the result register is full and stalled, the held request
//   stays in the input register and in_stall_o rises
//   reset: press state goes idle, registers take their default thresholds,
//   both channels empty
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ladder_key_decoder_core #(
  parameter int unsigned SAMPLES     = adckey_pkg::SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = adckey_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write port
  input  wire logic                              cfg_we_i,
  input  wire logic [adckey_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [adckey_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic                              kind_i,
  input  wire logic [SAMPLE_BITS-1:0]            sample_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [1:0]                        key_id_o,
  output      logic [1:0]                        press_class_o
);

  adckey_pkg::cfg_t    cfg;
  adckey_pkg::result_t result;
  adckey_pkg::status_t status;

  logic                   in_vld;
  logic                   in_kind;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_space;
  logic                   adv;      // decode step consumes the held request
  logic                   res_vld;
  logic                   push;

  // decode only when the result register can take a possible event
  assign adv  = in_vld && out_space;
  assign push = adv && res_vld;

  adckey_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  adckey_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .sample_i   (sample_i),
    .adv_i      (adv),
    .vld_o      (in_vld),
    .kind_o     (in_kind),
    .sample_o   (in_sample)
  );

  // press state, key and duration decode
  adckey_press_fsm #(
    .SAMPLES     (SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (adv),
    .kind_i    (in_kind),
    .sample_i  (in_sample),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .result_o  (result),
    .status_o  (status)
  );

  adckey_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .result_i      (result),
    .space_o       (out_space),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_id_o      (key_id_o),
    .press_class_o (press_class_o)
  );

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a decoded event shows up on the result channel next cycle
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("decoded event not presented");

  // an active press always has at least one summed sample
  a_tally_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == adckey_pkg::PH_IDLE) == status.tally_zero)
    else $error("sample tally out of step with press phase");

endmodule

`default_nettype wire

### tb/key_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_checker: key event scoreboard for the ladder keypad decoder
// Follows register writes and accepted requests, predicts the key events
// they cause and compares them in order with the events the decoder sends.
// ----------------------------------------------------------------------------
module key_event_checker
  import adckey_pkg::*;
#(
  parameter int unsigned SAMPLES     = SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   kind_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [1:0]             key_id_i,
  input  logic [1:0]             press_class_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     events_seen_o
);

  cfg_t             thresholds;
  logic [1:0]       press_phase;
  logic [SUM_W-1:0] level_sum;
  logic [3:0]       level_count;
  logic [MS_W-1:0]  held_ms;
  result_t          key_events_due[$];
  int               fails;
  int               seen;

  task automatic clear_press();
    press_phase = PH_IDLE;
    level_sum   = '0;
    level_count = '0;
    held_ms     = '0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_COMBO_LIMIT:       thresholds.combo_limit       = data[LIMIT_W-1:0];
      CFG_FIRST_KEY_LIMIT:   thresholds.first_key_limit   = data[LIMIT_W-1:0];
      CFG_SECOND_KEY_LIMIT:  thresholds.second_key_limit  = data[LIMIT_W-1:0];
      CFG_PRESS_THRESHOLD:   thresholds.press_threshold   = data[LIMIT_W-1:0];
      CFG_RELEASE_THRESHOLD: thresholds.release_threshold = data[LIMIT_W-1:0];
      CFG_CLICK_MIN_MS:      thresholds.click_min_ms      = data[MS_W-1:0];
      CFG_LONG_MIN_MS:       thresholds.long_min_ms       = data[MS_W-1:0];
      CFG_VERY_LONG_MIN_MS:  thresholds.very_long_min_ms  = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  // one accepted request through the press tracker
  task automatic decode_request(input logic is_tick, input logic [SAMPLE_BITS-1:0] level);
    logic [SUM_W:0]   wide_sum;
    logic [SUM_W-1:0] average;
    result_t          event_out;
    logic             reported;
    if (is_tick) begin
      if (press_phase != PH_IDLE && held_ms != {MS_W{1'b1}}) held_ms = held_ms + 1'b1;
    end else if (level < thresholds.press_threshold) begin
      if (press_phase == PH_IDLE) begin
        clear_press();
        press_phase = PH_SAMPLING;
      end
      if (press_phase == PH_SAMPLING) begin
        wide_sum    = {1'b0, level_sum} + level;
        level_sum   = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
        level_count = level_count + 1'b1;
        if (level_count >= SAMPLES) press_phase = PH_WAITING;
      end
    end else if (level > thresholds.release_threshold && press_phase != PH_IDLE &&
                 level_count != 0) begin
      average = level_sum / level_count;
      if (average < thresholds.combo_limit) event_out.key_id = KEY_COMBO;
      else if (average < thresholds.first_key_limit) event_out.key_id = KEY_NEXT;
      else if (average < thresholds.second_key_limit) event_out.key_id = KEY_RECORD;
      else event_out.key_id = KEY_PLAY;
      reported = 1'b1;
      if (held_ms > thresholds.very_long_min_ms) event_out.press_class = CLS_VERY_LONG;
      else if (held_ms > thresholds.long_min_ms) event_out.press_class = CLS_LONG;
      else if (held_ms > thresholds.click_min_ms) event_out.press_class = CLS_CLICK;
      else reported = 1'b0;
      if (reported) key_events_due.push_back(event_out);
      clear_press();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t due;
    if (!rst_ni) begin
      thresholds.combo_limit       = RST_COMBO_LIMIT;
      thresholds.first_key_limit   = RST_FIRST_KEY_LIMIT;
      thresholds.second_key_limit  = RST_SECOND_KEY_LIMIT;
      thresholds.press_threshold   = RST_PRESS_THRESHOLD;
      thresholds.release_threshold = RST_RELEASE_THRESHOLD;
      thresholds.click_min_ms      = RST_CLICK_MIN_MS;
      thresholds.long_min_ms       = RST_LONG_MIN_MS;
      thresholds.very_long_min_ms  = RST_VERY_LONG_MIN_MS;
      clear_press();
      key_events_due.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) decode_request(kind_i, sample_i);
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (key_events_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected key event, expected none, actual key %0d class %0d",
                   $time, key_id_i, press_class_i);
        end else begin
          due = key_events_due.pop_front();
          if (key_id_i !== due.key_id) begin
            fails++;
            $display("%0t: key_id expected %0d actual %0d", $time, due.key_id, key_id_i);
          end
          if (press_class_i !== due.press_class) begin
            fails++;
            $display("%0t: press_class expected %0d actual %0d",
                     $time, due.press_class, press_class_i);
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= key_events_due.size();
    events_seen_o <= seen;
  end

endmodule

### tb/adc_ladder_key_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder_core_test: testbench for the ladder keypad decoder
// Drives sample and tick requests as key presses with random levels and hold
// times over several threshold settings, with random gaps and output stalls;
// a separate scoreboard predicts every key event and checks it.
// ----------------------------------------------------------------------------
module adc_ladder_key_decoder_core_test;
  import adckey_pkg::*;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_TICK    = 1'b1;
  localparam int HOLD_CAP       = 100;    // longest random hold, in ticks
  localparam int HOLDOFF_CYCLES = 300;    // long output stall
  localparam int QUIET_LIMIT    = 2000;   // cycles with no transfer before giving up
  localparam int PHASE_ITEMS    = 300;
  localparam int PHASE_EVENTS   = 6;
  localparam int FIRST_TICKS    = 50;     // just past the reset click limit

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_kind   = 1'b0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [1:0]            key_id;
  logic [1:0]            press_class;

  int fail_count;
  int events_pending;
  int events_seen;

  // stimulus side bookkeeping
  cfg_t cfg_now;         // thresholds as last written, used to shape presses
  int   burst_left  = 0;
  int   press_items = 0; // requests that are part of a press
  int   holdoff_req = 0; // bumped to ask the receiver for one long stall
  int   quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  adc_ladder_key_decoder_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (in_kind),
    .sample_i      (in_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .key_id_o      (key_id),
    .press_class_o (press_class)
  );

  key_event_checker events_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .kind_i        (in_kind),
    .sample_i      (in_sample),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .key_id_i      (key_id),
    .press_class_i (press_class),
    .fail_count_o  (fail_count),
    .pending_o     (events_pending),
    .events_seen_o (events_seen)
  );

  // one request: bursts of back-to-back requests with random gaps between
  // them, returns at the edge that takes the request
  task automatic send_req(input logic kind, input logic [SAMPLE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst so whole presses go through without gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // let every key event come out, then wait on for a request that
  // gives no event but may still sit in the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all registers, 12-bit ones with junk in the unused upper bits
  task automatic apply_settings(input cfg_t c);
    logic [CFG_DATA_W-1:0] word [1 << CFG_IDX_W];
    word[CFG_COMBO_LIMIT]       = {4'($urandom_range(0, 15)), c.combo_limit};
    word[CFG_FIRST_KEY_LIMIT]   = {4'($urandom_range(0, 15)), c.first_key_limit};
    word[CFG_SECOND_KEY_LIMIT]  = {4'($urandom_range(0, 15)), c.second_key_limit};
    word[CFG_PRESS_THRESHOLD]   = {4'($urandom_range(0, 15)), c.press_threshold};
    word[CFG_RELEASE_THRESHOLD] = {4'($urandom_range(0, 15)), c.release_threshold};
    word[CFG_CLICK_MIN_MS]      = c.click_min_ms;
    word[CFG_LONG_MIN_MS]       = c.long_min_ms;
    word[CFG_VERY_LONG_MIN_MS]  = c.very_long_min_ms;
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= word[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  // hold time near a class boundary, or random when the boundary is far off
  function automatic int near_bound(input int bound);
    int r;
    if (bound > HOLD_CAP) return $urandom_range(0, HOLD_CAP);
    r = bound + int'($urandom_range(0, 2)) - 1;
    return (r < 0) ? 0 : r;
  endfunction

  function automatic int pick_hold();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 3);
      1:       return near_bound(int'(cfg_now.click_min_ms));
      2:       return near_bound(int'(cfg_now.long_min_ms));
      3:       return near_bound(int'(cfg_now.very_long_min_ms));
      default: return $urandom_range(0, HOLD_CAP);
    endcase
  endfunction

  // a request that does not start a press: idle tick, a level between the
  // thresholds, or a release level
  task automatic noise();
    case ($urandom_range(0, 2))
      0: send_req(KIND_TICK, SAMPLE_W'($urandom));
      1: begin
        if (cfg_now.press_threshold <= cfg_now.release_threshold)
          send_req(KIND_SAMPLE, SAMPLE_W'($urandom_range(cfg_now.press_threshold,
                                                         cfg_now.release_threshold)));
        else
          send_req(KIND_TICK, SAMPLE_W'($urandom));
      end
      default: begin
        if (cfg_now.release_threshold < SAMPLE_MAX)
          send_req(KIND_SAMPLE,
                   SAMPLE_W'($urandom_range(cfg_now.release_threshold + 1, SAMPLE_MAX)));
        else
          send_req(KIND_TICK, SAMPLE_W'($urandom));
      end
    endcase
  endtask

  // one key press: low samples jittering around one ladder level, ticks mixed
  // in and after, then a release; now and then the release is left out or a
  // stray request breaks into the press
  task automatic key_press();
    int n_low;
    int hold;
    int top;
    int level;
    int s;
    int sent;
    if (cfg_now.press_threshold == 0) begin
      noise();  // nothing can count as held down
      return;
    end
    n_low = $urandom_range(1, SAMPLES_DEF + 3);
    hold  = pick_hold();
    top   = int'(cfg_now.press_threshold) - 1;
    level = $urandom_range(0, top);
    sent  = 0;
    for (int i = 0; i < n_low; i++) begin
      s = level + int'($urandom_range(0, 64)) - 32;
      if (s < 0) s = 0;
      if (s > top) s = top;
      send_req(KIND_SAMPLE, SAMPLE_W'(s));
      sent++;
      if (hold > 0 && $urandom_range(0, 2) == 0) begin
        send_req(KIND_TICK, SAMPLE_W'($urandom));
        hold--;
        sent++;
      end
      if ($urandom_range(0, 11) == 0) noise();
    end
    sent += hold;
    repeat (hold) send_req(KIND_TICK, SAMPLE_W'($urandom));
    if ($urandom_range(0, 11) != 0 && cfg_now.release_threshold < SAMPLE_MAX) begin
      send_req(KIND_SAMPLE,
               SAMPLE_W'($urandom_range(cfg_now.release_threshold + 1, SAMPLE_MAX)));
      sent++;
    end
    press_items += sent;
  endtask

  // presses under the current thresholds until enough requests and key
  // events went by, with an upper bound for settings that rarely report
  task automatic run_presses();
    int items_at;
    int events_at;
    items_at  = press_items;
    events_at = events_seen;
    while ((press_items - items_at < PHASE_ITEMS || events_seen - events_at < PHASE_EVENTS) &&
           press_items - items_at < 2 * PHASE_ITEMS) begin
      if ($urandom_range(0, 5) == 0) noise();
      key_press();
    end
  endtask

  // receiver: stall pattern that changes mode at random intervals, plus
  // one long hold-off on request so the decoder backs up into its input
  initial begin : receiver
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    int          holdoff_taken;
    mode          = STALL_NONE;
    mode_left     = 0;
    hold_left     = 0;
    holdoff_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holdoff_req != holdoff_taken) begin
        holdoff_taken = holdoff_req;
        hold_left     = HOLDOFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          default:        out_stall <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  // watchdog: too long without any request or key event moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t c;
    cfg_now.combo_limit       = RST_COMBO_LIMIT;
    cfg_now.first_key_limit   = RST_FIRST_KEY_LIMIT;
    cfg_now.second_key_limit  = RST_SECOND_KEY_LIMIT;
    cfg_now.press_threshold   = RST_PRESS_THRESHOLD;
    cfg_now.release_threshold = RST_RELEASE_THRESHOLD;
    cfg_now.click_min_ms      = RST_CLICK_MIN_MS;
    cfg_now.long_min_ms       = RST_LONG_MIN_MS;
    cfg_now.very_long_min_ms  = RST_VERY_LONG_MIN_MS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: a record key held just past the click limit
    for (int i = 0; i < SAMPLES_DEF; i++) send_req(KIND_SAMPLE, SAMPLE_W'(1500 + 7 * i));
    repeat (FIRST_TICKS) send_req(KIND_TICK, SAMPLE_W'($urandom));
    send_req(KIND_SAMPLE, '1);
    drain();

    // directed presses with tiny class limits: click >1, long >2, very long >3
    c = cfg_now;
    c.click_min_ms     = 16'd1;
    c.long_min_ms      = 16'd2;
    c.very_long_min_ms = 16'd3;
    apply_settings(c);
    send_req(KIND_TICK, '1);          // tick while idle
    send_req(KIND_SAMPLE, '1);        // release level while idle
    send_req(KIND_SAMPLE, 12'd3400);  // between the thresholds
    send_req(KIND_SAMPLE, '0);        // lowest level, combo click
    send_req(KIND_TICK, '0);
    send_req(KIND_TICK, '1);
    send_req(KIND_SAMPLE, '1);
    send_req(KIND_SAMPLE, 12'd2999);  // just held, just released, too short
    send_req(KIND_SAMPLE, 12'd3801);
    send_req(KIND_SAMPLE, 12'd1400);  // release while still summing, record
    send_req(KIND_SAMPLE, 12'd3400);
    send_req(KIND_SAMPLE, 12'd1600);
    repeat (4) send_req(KIND_TICK, SAMPLE_W'($urandom));
    send_req(KIND_SAMPLE, 12'd3801);
    send_req(KIND_SAMPLE, 12'd500);   // next key, long press
    repeat (3) send_req(KIND_TICK, SAMPLE_W'($urandom));
    send_req(KIND_SAMPLE, 12'd4000);
    send_req(KIND_SAMPLE, 12'd2500);  // play key, click
    repeat (2) send_req(KIND_TICK, SAMPLE_W'($urandom));
    send_req(KIND_SAMPLE, '1);
    drain();

    // reset key limits, short class limits; the long receiver hold-off
    // lands here while events are frequent
    c.click_min_ms     = 16'd3;
    c.long_min_ms      = 16'd12;
    c.very_long_min_ms = 16'd25;
    apply_settings(c);
    holdoff_req <= holdoff_req + 1;
    run_presses();
    drain();

    // top extremes: everything below full scale is held, only full scale
    // releases, any tick at all makes a long press
    c.combo_limit       = '0;
    c.first_key_limit   = '1;
    c.second_key_limit  = '1;
    c.press_threshold   = '1;
    c.release_threshold = 12'd4094;
    c.click_min_ms      = '0;
    c.long_min_ms       = '0;
    c.very_long_min_ms  = '1;
    apply_settings(c);
    run_presses();
    drain();

    // bottom extremes with unordered limits: only zero is held, anything
    // above zero releases
    c.combo_limit       = '1;
    c.first_key_limit   = '0;
    c.second_key_limit  = '0;
    c.press_threshold   = 12'd1;
    c.release_threshold = '0;
    c.click_min_ms      = '0;
    c.long_min_ms       = '1;
    c.very_long_min_ms  = '0;
    apply_settings(c);
    run_presses();
    drain();

    // random key limits, press window and ordered class limits
    c.combo_limit       = LIMIT_W'($urandom_range(0, SAMPLE_MAX));
    c.first_key_limit   = LIMIT_W'($urandom_range(0, SAMPLE_MAX));
    c.second_key_limit  = LIMIT_W'($urandom_range(0, SAMPLE_MAX));
    c.press_threshold   = LIMIT_W'($urandom_range(500, SAMPLE_MAX));
    c.release_threshold = LIMIT_W'($urandom_range(c.press_threshold, 4000));
    c.click_min_ms      = MS_W'($urandom_range(0, 20));
    c.long_min_ms       = MS_W'(c.click_min_ms + $urandom_range(0, 30));
    c.very_long_min_ms  = MS_W'(c.long_min_ms + $urandom_range(0, 30));
    apply_settings(c);
    run_presses();
    drain();

    // reset key limits back, class limits out of order
    c.combo_limit       = RST_COMBO_LIMIT;
    c.first_key_limit   = RST_FIRST_KEY_LIMIT;
    c.second_key_limit  = RST_SECOND_KEY_LIMIT;
    c.press_threshold   = RST_PRESS_THRESHOLD;
    c.release_threshold = RST_RELEASE_THRESHOLD;
    c.click_min_ms      = 16'd30;
    c.long_min_ms       = 16'd10;
    c.very_long_min_ms  = 16'd20;
    apply_settings(c);
    run_presses();
    drain();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && events_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
